@@ src/linear_interp_resampler_core_defines.svh @@
// ---------------------------------------------------------------------------
// linear_interp_resampler_core_defines
// assertion macros used by the resampler sequencer
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lir_pkg.sv @@
// ---------------------------------------------------------------------------
// lir_pkg
// constants and types of the linear interpolation resampler
// ---------------------------------------------------------------------------
package lir_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int STEP_W      = 20;
	localparam int MAX_STRETCH = 8;
	localparam int POS_W       = STEP_W + 1;
	localparam int CNT_W       = $clog2(MAX_STRETCH + 1);
	localparam int DIFF_W      = SAMPLE_W + 1;
	localparam int ACC_W       = SAMPLE_W + FRAC_BITS + 2;

	localparam int POS_ONE    = 1 << FRAC_BITS;
	localparam int STEP_MIN   = (POS_ONE + MAX_STRETCH - 1) / MAX_STRETCH;
	localparam int STEP_RESET = 65536;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic [FRAC_BITS-1:0]       frac;
	} blend_req_t;

	typedef struct packed {
		logic load;
		logic run_end;
		logic clip_end;
	} emit_t;

endpackage

@@ src/lir_blend.sv @@
// ---------------------------------------------------------------------------
// lir_blend
// shared interpolation unit: registered multiply, then shift toward zero
// ---------------------------------------------------------------------------
module lir_blend (
	input  logic                                clk,
	input  lir_pkg::blend_req_t                 req,
	output logic signed [lir_pkg::SAMPLE_W-1:0] value
);
	import lir_pkg::*;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [ACC_W-1:0]    prod_s1;
	logic signed [SAMPLE_W-1:0] lo_s1;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    quo;
	logic                       adj;
	logic [ACC_W-1:0]           res;

	assign diff = DIFF_W'(req.hi) - DIFF_W'(req.lo);

	always_ff @(posedge clk) begin
		prod_s1 <= ACC_W'(diff * $signed({1'b0, req.frac}));
		lo_s1   <= req.lo;
	end

	// lo*one + (hi-lo)*f, then divide by one truncating toward zero
	assign acc   = (ACC_W'(lo_s1) <<< FRAC_BITS) + prod_s1;
	assign quo   = acc >>> FRAC_BITS;
	assign adj   = acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]);
	assign res   = quo + {{(ACC_W-1){1'b0}}, adj};
	assign value = res[SAMPLE_W-1:0];

endmodule

@@ src/lir_ctrl.sv @@
// ---------------------------------------------------------------------------
// lir_ctrl
// sequencer: walks output positions of one sample through the blend unit
// ---------------------------------------------------------------------------
`include "linear_interp_resampler_core_defines.svh"

module lir_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                final_sample,
	input  logic [lir_pkg::STEP_W-1:0]          step_cfg,
	input  logic                                out_free,
	output lir_pkg::blend_req_t                 req,
	output lir_pkg::emit_t                      emit
);
	import lir_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_LOAD  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [POS_W-1:0] ONE_P = POS_W'(POS_ONE);
	localparam logic [POS_W-1:0] TWO_P = POS_W'(2 * POS_ONE);

	logic [1:0]                 state_q;
	logic [POS_W-1:0]           pos_q;
	logic [STEP_W-1:0]          next_pos_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] cur_q;
	logic                       have_prev_q;
	logic                       last_q;
	logic                       phase_b_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [STEP_W-1:0]          step;
	logic [POS_W-1:0]           pos_n;
	logic                       tail_follows;
	logic                       last_out;
	logic                       accept;

	assign step   = (step_cfg < STEP_W'(STEP_MIN)) ? STEP_W'(STEP_MIN) : step_cfg;
	assign pos_n  = pos_q + POS_W'(step);
	assign accept = in_valid && !in_stall;

	assign in_stall = (state_q != ST_IDLE);

	assign req.lo   = phase_b_q ? cur_q : prev_q;
	assign req.hi   = cur_q;
	assign req.frac = pos_q[FRAC_BITS-1:0];

	// the tail interval still has outputs after this sweep ends
	assign tail_follows = !phase_b_q && last_q && (pos_n < TWO_P);
	assign last_out     = (cnt_q == CNT_W'(MAX_STRETCH - 1)) ||
	                      ((pos_n >= ONE_P) && !tail_follows);

	assign emit.load     = (state_q == ST_LOAD) && out_free;
	assign emit.run_end  = last_out;
	assign emit.clip_end = last_out && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			next_pos_q  <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			phase_b_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q     <= sample_value;
						last_q    <= final_sample;
						cnt_q     <= '0;
						pos_q     <= POS_W'(next_pos_q);
						phase_b_q <= !have_prev_q;
						state_q   <= (have_prev_q || final_sample) ? ST_CHECK : ST_DONE;
					end
				end
				ST_CHECK: begin
					if (pos_q >= ONE_P) begin
						pos_q <= pos_q - ONE_P;
						if (!phase_b_q && last_q) begin
							phase_b_q <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (cnt_q == CNT_W'(MAX_STRETCH)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						pos_q   <= pos_n;
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (last_q) begin
						prev_q      <= '0;
						have_prev_q <= 1'b0;
						next_pos_q  <= '0;
					end else begin
						prev_q      <= cur_q;
						have_prev_q <= 1'b1;
						next_pos_q  <= pos_q[STEP_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LIR_ASSERT_NOW(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_STRETCH),
		"output count above cap")
	`LIR_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE,
		"accepted transaction did not start work")
	`LIR_ASSERT_NOW(a_clip_is_run, clk, arst_n, emit.load && emit.clip_end, emit.run_end,
		"clip end without run end")
	`LIR_ASSERT_NOW(a_tail_last, clk, arst_n, state_q == ST_LOAD && phase_b_q, last_q,
		"tail sweep on a sample that is not final")

endmodule

@@ src/linear_interp_resampler_core.sv @@
// ---------------------------------------------------------------------------
// linear_interp_resampler_core
// linear interpolation resampler for signed 16-bit sample streams
// ---------------------------------------------------------------------------
// Each sample takes an accept step and a done step, plus per output it causes
// a check of the position, in which the product is registered, and a load of
// the blended value into the output register, plus one check for each sweep
// that ends; at most 8 outputs per sample, and a load waits while the output
// register is stalled. The pace is set by the single shared multiplier, used
// once per output under the sequencer. A new sample is taken only when the
// sequencer is idle; a finished output may still wait in the output register.
// The step register takes a write in any cycle and must only be written idle.
module linear_interp_resampler_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lir_pkg::STEP_W-1:0]          step_increment,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                final_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lir_pkg::SAMPLE_W-1:0] out_value,
	output logic                                run_end,
	output logic                                clip_end
);
	import lir_pkg::*;

	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic                       run_end_q;
	logic                       clip_end_q;
	logic                       out_free;
	blend_req_t                 req;
	emit_t                      emit;
	logic signed [SAMPLE_W-1:0] blend_value;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(STEP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			step_q <= step_increment;
		end
	end

	lir_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.final_sample (final_sample),
		.step_cfg     (step_q),
		.out_free     (out_free),
		.req          (req),
		.emit         (emit)
	);

	lir_blend u_blend (
		.clk   (clk),
		.req   (req),
		.value (blend_value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_value_q <= blend_value;
			run_end_q   <= emit.run_end;
			clip_end_q  <= emit.clip_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign run_end   = run_end_q;
	assign clip_end  = clip_end_q;

endmodule
